// ===== sv/ckbc_pkg.sv =====
// Shared types and constants for the counter keystream byte cipher.
// No dependencies; every other file imports this package.
package ckbc_pkg;

    // Finalizer mixing constants
    localparam logic [63:0] MURMUR_C1 = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] MURMUR_C2 = 64'hC4CEB9FE1A85EC53;
    localparam logic [63:0] SPLIT_C1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SPLIT_C2  = 64'h94D049BB133111EB;
    localparam logic [63:0] XSTAR_C   = 64'h2545F4914F6CDD1D;
    localparam logic [63:0] MUL_ONE   = 64'd1;

    // Register stages from input word to output register
    localparam int unsigned NUM_STAGES = 8;

    localparam int unsigned CFG_INDEX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VARIANT = 3'd0,
        CFG_KEY     = 3'd1,
        CFG_MULT    = 3'd2,
        CFG_COMBINE = 3'd3,
        CFG_DECRYPT = 3'd4
    } cfg_index_t;

    // Finalizer selection; the unused code behaves as murmur
    typedef enum logic [1:0] {
        FIN_MURMUR = 2'd0,
        FIN_SPLIT  = 2'd1,
        FIN_XSTAR  = 2'd2
    } fin_variant_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [1:0]  variant;
        logic [63:0] base_key;
        logic [63:0] step_mult;
        logic        combine_add;
        logic        decrypt;
    } cfg_t;

endpackage

// ===== sv/ckbc_cfg_regs.sv =====
// Configuration register file of the keystream cipher.
// Depends on ckbc_pkg for register indexes and the cfg_t bundle.
module ckbc_cfg_regs import ckbc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg          = cfg_reg;

    // Decode the write index; unknown indexes drop the word
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VARIANT: cfg_next.variant     = cfg_data[1:0];
                CFG_KEY:     cfg_next.base_key    = cfg_data;
                CFG_MULT:    cfg_next.step_mult   = cfg_data;
                CFG_COMBINE: cfg_next.combine_add = cfg_data[0];
                CFG_DECRYPT: cfg_next.decrypt     = cfg_data[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.variant     <= FIN_MURMUR;
            cfg_reg.base_key    <= 64'd0;
            cfg_reg.step_mult   <= 64'd1;
            cfg_reg.combine_add <= 1'b0;
            cfg_reg.decrypt     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/ckbc_mul64.sv =====
// Two-stage 64 x 64 multiplier keeping the low 64 bits of the product.
// Stage one forms 32 x 32 partial products, stage two sums them. Uses ckbc_pkg.
module ckbc_mul64 import ckbc_pkg::*; (
    input  logic        aclk,
    input  logic        en_pp,
    input  logic        en_sum,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] pp_low_reg;
    logic [31:0] pp_cross_reg;
    logic [63:0] prod_reg;
    logic [63:0] pp_low_next;
    logic [31:0] pp_cross_next;
    logic [63:0] prod_next;

    // Low product and the low halves of the two cross products
    always_comb begin
        pp_low_next   = {32'd0, op_a[31:0]} * {32'd0, op_b[31:0]};
        pp_cross_next = (op_a[31:0] * op_b[63:32]) + (op_a[63:32] * op_b[31:0]);
    end

    // Fold cross terms into the upper word
    assign prod_next = pp_low_reg + {pp_cross_reg, 32'd0};
    assign prod      = prod_reg;

    always_ff @(posedge aclk) begin
        if (en_pp) begin
            pp_low_reg   <= pp_low_next;
            pp_cross_reg <= pp_cross_next;
        end
        if (en_sum) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== sv/counter_keystream_byte_cipher_top.sv =====
// Top level of the counter keystream byte cipher: pipeline control, mixing steps, combine.
// Depends on ckbc_pkg, ckbc_cfg_regs and ckbc_mul64.
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  input   | s_valid s_ready s_data_byte s_position | in
//  result  | m_valid m_ready m_result_byte       | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in
//
// One word per cycle is sustained while m_ready is high.
// The three chained 64-bit multiplies (counter, first mix, second mix), two stages each,
// plus the key add and output stages set the depth.
// Each stage loads when it is empty or its successor moves, so bubbles close up under stall.
// Reset (aresetn low, synchronous) clears all valid bits and restores register defaults.
module counter_keystream_byte_cipher_top import ckbc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic [31:0]            s_position,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_result_byte,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    cfg_t cfg;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    logic [7:0]  data_reg [NUM_STAGES-1];
    logic [63:0] key_sum_reg;
    logic [63:0] key_sum_next;
    logic [7:0]  result_reg;
    logic [7:0]  result_next;

    logic [31:0] count;
    logic [63:0] cnt_prod;
    logic [63:0] mix1_in;
    logic [63:0] mix1_const;
    logic [63:0] mix1_prod;
    logic [63:0] mix2_in;
    logic [63:0] mix2_const;
    logic [63:0] mix2_prod;
    logic [63:0] xs1;
    logic [63:0] xs2;
    logic [63:0] xs3;
    logic [7:0]  ks_byte;

    ckbc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage loads when empty or when its content moves on
    always_comb begin
        load[NUM_STAGES-1] = ~valid_reg[NUM_STAGES-1] | m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            load[i] = ~valid_reg[i] | load[i+1];
        end
        valid_next = valid_reg;
        if (load[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (load[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    assign s_ready       = load[0];
    assign m_valid       = valid_reg[NUM_STAGES-1];
    assign m_result_byte = result_reg;

    // Counter wraps in 32 bits
    assign count = s_position + 32'd1;

    // Stages 0-1: count times step multiplier
    ckbc_mul64 u_mul_cnt (
        .aclk   (aclk),
        .en_pp  (load[0]),
        .en_sum (load[1]),
        .op_a   ({32'd0, count}),
        .op_b   (cfg.step_mult),
        .prod   (cnt_prod)
    );

    // Stage 2: add base key
    assign key_sum_next = cfg.base_key + cnt_prod;

    // First mixing step ahead of the first constant multiply
    always_comb begin
        xs1 = key_sum_reg ^ (key_sum_reg << 13);
        xs2 = xs1 ^ (xs1 >> 7);
        xs3 = xs2 ^ (xs2 << 17);
        unique case (cfg.variant)
            FIN_SPLIT: begin
                mix1_in    = key_sum_reg ^ (key_sum_reg >> 30);
                mix1_const = SPLIT_C1;
            end
            FIN_XSTAR: begin
                mix1_in    = xs3;
                mix1_const = XSTAR_C;
            end
            default: begin
                mix1_in    = key_sum_reg ^ (key_sum_reg >> 33);
                mix1_const = MURMUR_C1;
            end
        endcase
    end

    // Stages 3-4: first constant multiply
    ckbc_mul64 u_mul_mix1 (
        .aclk   (aclk),
        .en_pp  (load[3]),
        .en_sum (load[4]),
        .op_a   (mix1_in),
        .op_b   (mix1_const),
        .prod   (mix1_prod)
    );

    // Second mixing step; xorshift star passes through times one
    always_comb begin
        unique case (cfg.variant)
            FIN_SPLIT: begin
                mix2_in    = mix1_prod ^ (mix1_prod >> 27);
                mix2_const = SPLIT_C2;
            end
            FIN_XSTAR: begin
                mix2_in    = mix1_prod;
                mix2_const = MUL_ONE;
            end
            default: begin
                mix2_in    = mix1_prod ^ (mix1_prod >> 33);
                mix2_const = MURMUR_C2;
            end
        endcase
    end

    // Stages 5-6: second constant multiply
    ckbc_mul64 u_mul_mix2 (
        .aclk   (aclk),
        .en_pp  (load[5]),
        .en_sum (load[6]),
        .op_a   (mix2_in),
        .op_b   (mix2_const),
        .prod   (mix2_prod)
    );

    // Final xor shift (none for xorshift star), low byte only
    always_comb begin
        unique case (cfg.variant)
            FIN_SPLIT: ks_byte = mix2_prod[7:0] ^ mix2_prod[38:31];
            FIN_XSTAR: ks_byte = mix2_prod[7:0];
            default:   ks_byte = mix2_prod[7:0] ^ mix2_prod[40:33];
        endcase
    end

    // Combine data with keystream byte
    always_comb begin
        priority if (!cfg.combine_add) begin
            result_next = data_reg[NUM_STAGES-2] ^ ks_byte;
        end else if (cfg.decrypt) begin
            result_next = data_reg[NUM_STAGES-2] - ks_byte;
        end else begin
            result_next = data_reg[NUM_STAGES-2] + ks_byte;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload: data byte travels alongside the keystream
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            data_reg[0] <= s_data_byte;
        end
        for (int i = 1; i < NUM_STAGES - 1; i++) begin
            if (load[i]) begin
                data_reg[i] <= data_reg[i-1];
            end
        end
        if (load[2]) begin
            key_sum_reg <= key_sum_next;
        end
        if (load[NUM_STAGES-1]) begin
            result_reg <= result_next;
        end
    end

    // A full, stalled pipe must refuse input
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((&valid_reg) && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline full and stalled");

    // An empty first stage always takes input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0] |-> s_ready)
        else $error("empty first stage refused input");

    // A word moving from stage 0 lands in stage 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[0] && load[1]) |=> valid_reg[1])
        else $error("word lost between stage 0 and stage 1");

    // A result held under stall stays valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[NUM_STAGES-1] && !load[NUM_STAGES-1]) |=> valid_reg[NUM_STAGES-1])
        else $error("stalled result dropped");

endmodule
